[hdl/imes_pkg.sv]
// Shared types, codes and constants for the I2C master event sequencer.
package imes_pkg;

   localparam int NUM_SLOTS = 6;

   localparam logic [15:0] MAX_LEN = 16'd255;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_EVENT = 2'd2;

   localparam logic [1:0] ST_READY = 2'd0;
   localparam logic [1:0] ST_TX    = 2'd1;
   localparam logic [1:0] ST_RX    = 2'd2;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_TX_DONE  = 3'd1;
   localparam logic [2:0] EV_RX_DONE  = 3'd2;
   localparam logic [2:0] EV_STOP     = 3'd3;
   localparam logic [2:0] EV_SLV_REQ  = 3'd4;
   localparam logic [2:0] EV_SLV_RECV = 3'd5;

   localparam int FLAG_SB     = 0;
   localparam int FLAG_ADDR   = 1;
   localparam int FLAG_BTF    = 2;
   localparam int FLAG_STOPF  = 3;
   localparam int FLAG_TXE    = 4;
   localparam int FLAG_RXNE   = 5;
   localparam int FLAG_MASTER = 6;
   localparam int FLAG_TRA    = 7;

   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] slave_addr;
      logic [7:0] length;
      logic       repeated_start;
      logic [7:0] status_flags;
      logic [7:0] tx_byte;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] busy_state;
      logic       gen_start;
      logic       gen_stop;
      logic       clear_addr;
      logic       dr_write_valid;
      logic [7:0] dr_write_value;
      logic       ack_bit;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [2:0] app_event;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] xfer_state;
      logic [6:0] target_addr;
      logic [7:0] tx_remaining;
      logic [7:0] rx_remaining;
      logic [7:0] rx_total;
      logic       hold_bus;
      logic       event_irq_on;
      logic       buffer_irq_on;
      logic       ack_state;
   } seq_state_type;

endpackage

[hdl/imes_req_if.sv]
// Request channel interface carrying start commands and bus status events.
interface imes_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [6:0] slave_addr;
   logic [7:0] length;
   logic       repeated_start;
   logic [7:0] status_flags;
   logic [7:0] tx_byte;
   logic [7:0] rx_byte;

   modport source (output valid, cmd, slave_addr, length, repeated_start, status_flags,
                   tx_byte, rx_byte, input ready);
   modport sink (input valid, cmd, slave_addr, length, repeated_start, status_flags,
                 tx_byte, rx_byte, output ready);
endinterface

[hdl/imes_rsp_if.sv]
// Response channel interface carrying the sequencer's result items.
interface imes_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] busy_state;
   logic       gen_start;
   logic       gen_stop;
   logic       clear_addr;
   logic       dr_write_valid;
   logic [7:0] dr_write_value;
   logic       ack_bit;
   logic       rx_valid;
   logic [7:0] rx_data;
   logic [2:0] app_event;
   logic       last;

   modport source (output valid, busy_state, gen_start, gen_stop, clear_addr,
                   dr_write_valid, dr_write_value, ack_bit, rx_valid, rx_data,
                   app_event, last, input ready);
   modport sink (input valid, busy_state, gen_start, gen_stop, clear_addr,
                 dr_write_valid, dr_write_value, ack_bit, rx_valid, rx_data,
                 app_event, last, output ready);
endinterface

[hdl/imes_csr_if.sv]
// Configuration write channel interface for the ACK default register.
interface imes_csr_if;
   logic valid;
   logic ready;
   logic ack_default;

   modport source (output valid, ack_default, input ready);
   modport sink (input valid, ack_default, output ready);
endinterface

[hdl/i2c_master_event_sequencer_unit.sv]
// Top level of the interrupt-driven I2C master transfer sequencer.
// The first result of a request is offered in the cycle after its transfer.
// Throughput: one request per cycle while each request yields one result and that
// result is taken; a request with more results holds the result registers until
// its last result is taken. Reset clears the transfer state, interrupt enables and
// counts, and sets ACK and the ACK default to enabled.
module i2c_master_event_sequencer_unit #(
   parameter logic [15:0] MAX_LEN = imes_pkg::MAX_LEN
) (
   input  logic       clock,
   input  logic       reset,
   imes_req_if.sink   req_ch,
   imes_rsp_if.source rsp_ch,
   imes_csr_if.sink   csr_ch
);
   import imes_pkg::*;

   localparam seq_state_type STATE_RESET = '{
      xfer_state:    ST_READY,
      target_addr:   7'd0,
      tx_remaining:  8'd0,
      rx_remaining:  8'd0,
      rx_total:      8'd0,
      hold_bus:      1'b0,
      event_irq_on:  1'b0,
      buffer_irq_on: 1'b0,
      ack_state:     1'b1
   };

   seq_state_type        state_ff;
   seq_state_type        state_in;
   seq_state_type        step_state;
   logic                 ack_default_ff;
   logic                 ack_default_in;
   req_item_type         req_item;
   rsp_item_type         slot [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] slot_valid;
   rsp_item_type         rsp_item;
   logic                 rsp_last;
   logic                 can_load;
   logic                 req_xfer;

   assign req_item.cmd            = req_ch.cmd;
   assign req_item.slave_addr     = req_ch.slave_addr;
   assign req_item.length         = req_ch.length;
   assign req_item.repeated_start = req_ch.repeated_start;
   assign req_item.status_flags   = req_ch.status_flags;
   assign req_item.tx_byte        = req_ch.tx_byte;
   assign req_item.rx_byte        = req_ch.rx_byte;

   assign req_ch.ready = can_load;
   assign req_xfer     = req_ch.valid && can_load;
   assign csr_ch.ready = 1'b1;

   imes_step #(
      .MAX_LEN (MAX_LEN)
   ) u_step (
      .state_i       (state_ff),
      .req_i         (req_item),
      .ack_default_i (ack_default_ff),
      .state_o       (step_state),
      .slot_o        (slot),
      .slot_valid_o  (slot_valid)
   );

   imes_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .load_i       (req_xfer),
      .slot_i       (slot),
      .slot_valid_i (slot_valid),
      .rsp_ready_i  (rsp_ch.ready),
      .rsp_valid_o  (rsp_ch.valid),
      .rsp_item_o   (rsp_item),
      .rsp_last_o   (rsp_last),
      .can_load_o   (can_load)
   );

   assign state_in       = req_xfer ? step_state : state_ff;
   assign ack_default_in = csr_ch.valid ? csr_ch.ack_default : ack_default_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= STATE_RESET;
         ack_default_ff <= 1'b1;
      end else begin
         state_ff       <= state_in;
         ack_default_ff <= ack_default_in;
      end
   end

   assign rsp_ch.busy_state     = rsp_item.busy_state;
   assign rsp_ch.gen_start      = rsp_item.gen_start;
   assign rsp_ch.gen_stop       = rsp_item.gen_stop;
   assign rsp_ch.clear_addr     = rsp_item.clear_addr;
   assign rsp_ch.dr_write_valid = rsp_item.dr_write_valid;
   assign rsp_ch.dr_write_value = rsp_item.dr_write_value;
   assign rsp_ch.ack_bit        = rsp_item.ack_bit;
   assign rsp_ch.rx_valid       = rsp_item.rx_valid;
   assign rsp_ch.rx_data        = rsp_item.rx_data;
   assign rsp_ch.app_event      = rsp_item.app_event;
   assign rsp_ch.last           = rsp_last;

endmodule

[hdl/imes_step.sv]
// Combinational handler pass that turns one request into up to six result slots.
module imes_step #(
   parameter logic [15:0] MAX_LEN = imes_pkg::MAX_LEN
) (
   input  imes_pkg::seq_state_type state_i,
   input  imes_pkg::req_item_type  req_i,
   input  logic                    ack_default_i,
   output imes_pkg::seq_state_type state_o,
   output imes_pkg::rsp_item_type  slot_o [imes_pkg::NUM_SLOTS],
   output logic [imes_pkg::NUM_SLOTS-1:0] slot_valid_o
);
   import imes_pkg::*;

   function automatic rsp_item_type mk_item(input logic [1:0] busy, input logic start,
                                            input logic stop, input logic clr,
                                            input logic dwv, input logic [7:0] dwval,
                                            input logic ack, input logic rxv,
                                            input logic [7:0] rxd, input logic [2:0] ev);
      rsp_item_type it;
      it.busy_state     = busy;
      it.gen_start      = start;
      it.gen_stop       = stop;
      it.clear_addr     = clr;
      it.dr_write_valid = dwv;
      it.dr_write_value = dwv ? dwval : 8'd0;
      it.ack_bit        = ack;
      it.rx_valid       = rxv;
      it.rx_data        = rxv ? rxd : 8'd0;
      it.app_event      = ev;
      return it;
   endfunction

   seq_state_type st;
   rsp_item_type  slot [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] vld;
   logic [7:0] len_c;
   logic       ev_en;
   logic       buf_en;
   logic       master;
   logic       tra;
   logic       got;
   logic       stop;
   logic [2:0] evc;

   always_comb begin
      st     = state_i;
      vld    = '0;
      got    = 1'b0;
      stop   = 1'b0;
      evc    = EV_NONE;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot[i] = '0;
      end
      len_c  = ({8'd0, req_i.length} > MAX_LEN) ? MAX_LEN[7:0] : req_i.length;
      ev_en  = state_i.event_irq_on;
      buf_en = state_i.buffer_irq_on;
      master = req_i.status_flags[FLAG_MASTER];
      tra    = req_i.status_flags[FLAG_TRA];

      unique case (req_i.cmd)
         CMD_WRITE, CMD_READ: begin
            if (state_i.xfer_state == ST_TX || state_i.xfer_state == ST_RX) begin
               slot[0] = mk_item(state_i.xfer_state, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,
                                 st.ack_state, 1'b0, 8'd0, EV_NONE);
               vld[0]  = 1'b1;
            end else begin
               st.target_addr = req_i.slave_addr;
               st.hold_bus    = req_i.repeated_start;
               if (req_i.cmd == CMD_WRITE) begin
                  st.tx_remaining = len_c;
                  st.xfer_state   = ST_TX;
               end else begin
                  st.rx_remaining = len_c;
                  st.rx_total     = len_c;
                  st.xfer_state   = ST_RX;
               end
               st.event_irq_on  = 1'b1;
               st.buffer_irq_on = 1'b1;
               slot[0] = mk_item(state_i.xfer_state, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0,
                                 st.ack_state, 1'b0, 8'd0, EV_NONE);
               vld[0]  = 1'b1;
            end
         end
         CMD_EVENT: begin
            // Start condition sent: put the address byte with the direction bit out.
            if (ev_en && req_i.status_flags[FLAG_SB]) begin
               if (st.xfer_state == ST_TX) begin
                  slot[0] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b1,
                                    {st.target_addr, 1'b0}, st.ack_state, 1'b0, 8'd0,
                                    EV_NONE);
                  vld[0]  = 1'b1;
               end else if (st.xfer_state == ST_RX) begin
                  slot[0] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b1,
                                    {st.target_addr, 1'b1}, st.ack_state, 1'b0, 8'd0,
                                    EV_NONE);
                  vld[0]  = 1'b1;
               end
            end
            if (ev_en && req_i.status_flags[FLAG_ADDR]) begin
               if (master && st.xfer_state == ST_RX && st.rx_total == 8'd1) begin
                  st.ack_state = 1'b0;
               end
               slot[1] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0,
                                 st.ack_state, 1'b0, 8'd0, EV_NONE);
               vld[1]  = 1'b1;
            end
            if (ev_en && req_i.status_flags[FLAG_BTF]) begin
               if (st.xfer_state == ST_TX && st.tx_remaining == 8'd0) begin
                  st.event_irq_on  = 1'b0;
                  st.buffer_irq_on = 1'b0;
                  st.tx_remaining  = 8'd0;
                  st.rx_remaining  = 8'd0;
                  st.rx_total      = 8'd0;
                  st.xfer_state    = ST_READY;
                  slot[2] = mk_item(st.xfer_state, 1'b0, ~st.hold_bus, 1'b0, 1'b0, 8'd0,
                                    st.ack_state, 1'b0, 8'd0, EV_TX_DONE);
                  vld[2]  = 1'b1;
               end
            end
            if (ev_en && req_i.status_flags[FLAG_STOPF]) begin
               slot[3] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,
                                 st.ack_state, 1'b0, 8'd0, EV_STOP);
               vld[3]  = 1'b1;
            end
            if (ev_en && buf_en && req_i.status_flags[FLAG_TXE]) begin
               if (master) begin
                  if (st.xfer_state == ST_TX && st.tx_remaining != 8'd0) begin
                     st.tx_remaining = st.tx_remaining - 8'd1;
                     slot[4] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b1,
                                       req_i.tx_byte, st.ack_state, 1'b0, 8'd0, EV_NONE);
                     vld[4]  = 1'b1;
                  end
               end else if (tra) begin
                  slot[4] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,
                                    st.ack_state, 1'b0, 8'd0, EV_SLV_REQ);
                  vld[4]  = 1'b1;
               end
            end
            if (ev_en && buf_en && req_i.status_flags[FLAG_RXNE]) begin
               if (master) begin
                  if (st.xfer_state == ST_RX) begin
                     if (st.rx_total != 8'd0) begin
                        if (st.rx_total > 8'd1 && st.rx_remaining == 8'd2) begin
                           st.ack_state = 1'b0;
                        end
                        got = 1'b1;
                        if (st.rx_remaining != 8'd0) begin
                           st.rx_remaining = st.rx_remaining - 8'd1;
                        end
                     end
                     if (st.rx_remaining == 8'd0) begin
                        stop             = ~st.hold_bus;
                        st.event_irq_on  = 1'b0;
                        st.buffer_irq_on = 1'b0;
                        st.tx_remaining  = 8'd0;
                        st.rx_remaining  = 8'd0;
                        st.rx_total      = 8'd0;
                        st.xfer_state    = ST_READY;
                        if (ack_default_i) begin
                           st.ack_state = 1'b1;
                        end
                        evc = EV_RX_DONE;
                     end
                     slot[5] = mk_item(st.xfer_state, 1'b0, stop, 1'b0, 1'b0, 8'd0,
                                       st.ack_state, got, req_i.rx_byte, evc);
                     vld[5]  = 1'b1;
                  end
               end else if (!tra) begin
                  slot[5] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,
                                    st.ack_state, 1'b0, 8'd0, EV_SLV_RECV);
                  vld[5]  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // A request that triggers no handler still answers with one idle transfer.
      if (vld == '0) begin
         slot[0] = mk_item(st.xfer_state, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,
                           st.ack_state, 1'b0, 8'd0, EV_NONE);
         vld[0]  = 1'b1;
      end
   end

   assign state_o      = st;
   assign slot_o       = slot;
   assign slot_valid_o = vld;

endmodule

[hdl/imes_rsp_buf.sv]
// Result register bank that delivers the pending slots of one request in order.
module imes_rsp_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_i,
   input  imes_pkg::rsp_item_type        slot_i [imes_pkg::NUM_SLOTS],
   input  logic [imes_pkg::NUM_SLOTS-1:0] slot_valid_i,
   input  logic                          rsp_ready_i,
   output logic                          rsp_valid_o,
   output imes_pkg::rsp_item_type        rsp_item_o,
   output logic                          rsp_last_o,
   output logic                          can_load_o
);
   import imes_pkg::*;

   rsp_item_type         slots_ff [NUM_SLOTS];
   rsp_item_type         slots_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] pend_ff;
   logic [NUM_SLOTS-1:0] pend_in;
   logic [NUM_SLOTS-1:0] sel_oh;
   rsp_item_type         cur;
   logic                 xfer_done;

   always_comb begin
      sel_oh = pend_ff & (~pend_ff + NUM_SLOTS'(1));
      cur    = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (sel_oh[i]) begin
            cur = cur | slots_ff[i];
         end
      end
   end

   assign rsp_valid_o = pend_ff != '0;
   assign rsp_item_o  = cur;
   assign rsp_last_o  = (pend_ff & ~sel_oh) == '0;
   assign xfer_done   = rsp_valid_o && rsp_ready_i;
   assign can_load_o  = !rsp_valid_o || (xfer_done && rsp_last_o);

   always_comb begin
      slots_in = slots_ff;
      pend_in  = pend_ff;
      if (load_i) begin
         slots_in = slot_i;
         pend_in  = slot_valid_i;
      end else if (xfer_done) begin
         pend_in = pend_ff & ~sel_oh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
      slots_ff <= slots_in;
   end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the I2C master event sequencer: directed and random traffic.
module tb_top;
   import imes_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PRINT_LIMIT = 50;
   localparam int RANDOM_ITEMS_PER_PHASE = 50;

   localparam logic [7:0] F_SB     = 8'h01 << FLAG_SB;
   localparam logic [7:0] F_ADDR   = 8'h01 << FLAG_ADDR;
   localparam logic [7:0] F_BTF    = 8'h01 << FLAG_BTF;
   localparam logic [7:0] F_STOPF  = 8'h01 << FLAG_STOPF;
   localparam logic [7:0] F_TXE    = 8'h01 << FLAG_TXE;
   localparam logic [7:0] F_RXNE   = 8'h01 << FLAG_RXNE;
   localparam logic [7:0] F_MASTER = 8'h01 << FLAG_MASTER;
   localparam logic [7:0] F_TRA    = 8'h01 << FLAG_TRA;
   localparam logic [7:0] F_MT     = F_MASTER | F_TRA;

   typedef struct packed {
      rsp_item_type body;
      logic         last;
   } bus_action_type;

   logic clock = 1'b0;
   logic reset;

   imes_req_if req_ch();
   imes_rsp_if rsp_ch();
   imes_csr_if csr_ch();

   i2c_master_event_sequencer_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // Sequencer state as the testbench expects it to be.
   logic [1:0] bus_state   = ST_READY;
   logic [6:0] dest_addr   = '0;
   logic [7:0] tx_left     = '0;
   logic [7:0] rx_left     = '0;
   logic [7:0] rx_count    = '0;
   logic       keep_bus    = 1'b0;
   logic       evt_irq_en  = 1'b0;
   logic       buf_irq_en  = 1'b0;
   logic       ack_en      = 1'b1;
   logic       ack_restore = 1'b1;

   bus_action_type expected_actions[$];

   int error_count   = 0;
   int items_sent    = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic void push_action(input logic [1:0] busy, input logic start,
                                       input logic stop, input logic clr,
                                       input logic dwv, input logic [7:0] dwval,
                                       input logic rxv, input logic [7:0] rxd,
                                       input logic [2:0] app_ev);
      bus_action_type a;
      a.body.busy_state     = busy;
      a.body.gen_start      = start;
      a.body.gen_stop       = stop;
      a.body.clear_addr     = clr;
      a.body.dr_write_valid = dwv;
      a.body.dr_write_value = dwv ? dwval : 8'd0;
      a.body.ack_bit        = ack_en;
      a.body.rx_valid       = rxv;
      a.body.rx_data        = rxv ? rxd : 8'd0;
      a.body.app_event      = app_ev;
      a.last                = 1'b0;
      expected_actions.push_back(a);
   endfunction

   function automatic void close_transfer();
      evt_irq_en = 1'b0;
      buf_irq_en = 1'b0;
      tx_left    = '0;
      rx_left    = '0;
      rx_count   = '0;
      bus_state  = ST_READY;
   endfunction

   function automatic void predict_bus_actions(input req_item_type it);
      int         first;
      logic       ev_en;
      logic       buf_en;
      logic       master;
      logic       tra;
      logic       got;
      logic       stop;
      logic [2:0] app_ev;
      logic [7:0] len;
      first = expected_actions.size();
      len = (16'(it.length) > MAX_LEN) ? MAX_LEN[7:0] : it.length;
      case (it.cmd)
         CMD_WRITE, CMD_READ: begin
            if (bus_state == ST_TX || bus_state == ST_RX) begin
               push_action(bus_state, 0, 0, 0, 0, 0, 0, 0, EV_NONE);
            end else begin
               dest_addr = it.slave_addr;
               keep_bus  = it.repeated_start;
               if (it.cmd == CMD_WRITE) begin
                  tx_left   = len;
                  bus_state = ST_TX;
               end else begin
                  rx_left   = len;
                  rx_count  = len;
                  bus_state = ST_RX;
               end
               evt_irq_en = 1'b1;
               buf_irq_en = 1'b1;
               push_action(ST_READY, 1, 0, 0, 0, 0, 0, 0, EV_NONE);
            end
         end
         CMD_EVENT: begin
            ev_en  = evt_irq_en;
            buf_en = buf_irq_en;
            master = it.status_flags[FLAG_MASTER];
            tra    = it.status_flags[FLAG_TRA];
            if (ev_en && it.status_flags[FLAG_SB]) begin
               if (bus_state == ST_TX) begin
                  push_action(bus_state, 0, 0, 0, 1, {dest_addr, 1'b0}, 0, 0, EV_NONE);
               end else if (bus_state == ST_RX) begin
                  push_action(bus_state, 0, 0, 0, 1, {dest_addr, 1'b1}, 0, 0, EV_NONE);
               end
            end
            if (ev_en && it.status_flags[FLAG_ADDR]) begin
               if (master && bus_state == ST_RX && rx_count == 8'd1) ack_en = 1'b0;
               push_action(bus_state, 0, 0, 1, 0, 0, 0, 0, EV_NONE);
            end
            if (ev_en && it.status_flags[FLAG_BTF] && bus_state == ST_TX && tx_left == 0) begin
               stop = !keep_bus;
               close_transfer();
               push_action(bus_state, 0, stop, 0, 0, 0, 0, 0, EV_TX_DONE);
            end
            if (ev_en && it.status_flags[FLAG_STOPF]) begin
               push_action(bus_state, 0, 0, 0, 0, 0, 0, 0, EV_STOP);
            end
            if (ev_en && buf_en && it.status_flags[FLAG_TXE]) begin
               if (master) begin
                  if (bus_state == ST_TX && tx_left != 0) begin
                     tx_left = tx_left - 8'd1;
                     push_action(bus_state, 0, 0, 0, 1, it.tx_byte, 0, 0, EV_NONE);
                  end
               end else if (tra) begin
                  push_action(bus_state, 0, 0, 0, 0, 0, 0, 0, EV_SLV_REQ);
               end
            end
            if (ev_en && buf_en && it.status_flags[FLAG_RXNE]) begin
               if (master) begin
                  if (bus_state == ST_RX) begin
                     got    = 1'b0;
                     stop   = 1'b0;
                     app_ev = EV_NONE;
                     if (rx_count >= 8'd1) begin
                        if (rx_count > 8'd1 && rx_left == 8'd2) ack_en = 1'b0;
                        got = 1'b1;
                        if (rx_left != 0) rx_left = rx_left - 8'd1;
                     end
                     if (rx_left == 0) begin
                        stop = !keep_bus;
                        close_transfer();
                        if (ack_restore) ack_en = 1'b1;
                        app_ev = EV_RX_DONE;
                     end
                     push_action(bus_state, 0, stop, 0, 0, 0, got, it.rx_byte, app_ev);
                  end
               end else if (!tra) begin
                  push_action(bus_state, 0, 0, 0, 0, 0, 0, 0, EV_SLV_RECV);
               end
            end
         end
         default: ;
      endcase
      if (expected_actions.size() == first) begin
         push_action(bus_state, 0, 0, 0, 0, 0, 0, 0, EV_NONE);
      end
      expected_actions[expected_actions.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      bus_action_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_actions.size() == 0) begin
            report_mismatch("result transfer with no expected result");
         end else begin
            want = expected_actions.pop_front();
            check_field("busy_state", 8'(rsp_ch.busy_state), 8'(want.body.busy_state));
            check_field("gen_start", 8'(rsp_ch.gen_start), 8'(want.body.gen_start));
            check_field("gen_stop", 8'(rsp_ch.gen_stop), 8'(want.body.gen_stop));
            check_field("clear_addr", 8'(rsp_ch.clear_addr), 8'(want.body.clear_addr));
            check_field("dr_write_valid", 8'(rsp_ch.dr_write_valid),
                        8'(want.body.dr_write_valid));
            check_field("dr_write_value", rsp_ch.dr_write_value, want.body.dr_write_value);
            check_field("ack_bit", 8'(rsp_ch.ack_bit), 8'(want.body.ack_bit));
            check_field("rx_valid", 8'(rsp_ch.rx_valid), 8'(want.body.rx_valid));
            check_field("rx_data", rsp_ch.rx_data, want.body.rx_data);
            check_field("app_event", 8'(rsp_ch.app_event), 8'(want.body.app_event));
            check_field("last", 8'(rsp_ch.last), 8'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic req_item_type random_item();
      req_item_type it;
      it.cmd            = 2'($urandom_range(3));
      it.slave_addr     = 7'($urandom);
      it.length         = 8'($urandom_range(15));
      it.repeated_start = 1'($urandom);
      it.status_flags   = 8'($urandom);
      it.tx_byte        = 8'($urandom);
      it.rx_byte        = 8'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] pick_length();
      if ($urandom_range(9) == 0) return 8'($urandom_range(6, 40));
      return 8'($urandom_range(5));
   endfunction

   task automatic send_item(input req_item_type it);
      req_ch.valid          <= 1'b1;
      req_ch.cmd            <= it.cmd;
      req_ch.slave_addr     <= it.slave_addr;
      req_ch.length         <= it.length;
      req_ch.repeated_start <= it.repeated_start;
      req_ch.status_flags   <= it.status_flags;
      req_ch.tx_byte        <= it.tx_byte;
      req_ch.rx_byte        <= it.rx_byte;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_bus_actions(it);
      items_sent++;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_start(input logic [1:0] cmd, input logic [6:0] addr,
                             input logic [7:0] len, input logic hold);
      req_item_type it;
      it                = random_item();
      it.cmd            = cmd;
      it.slave_addr     = addr;
      it.length         = len;
      it.repeated_start = hold;
      send_item(it);
   endtask

   task automatic send_event(input logic [7:0] flags, input logic [7:0] txb,
                             input logic [7:0] rxb);
      req_item_type it;
      it              = random_item();
      it.cmd          = CMD_EVENT;
      it.status_flags = flags;
      it.tx_byte      = txb;
      it.rx_byte      = rxb;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
   endtask

   task automatic write_ack_default(input logic value);
      csr_ch.valid       <= 1'b1;
      csr_ch.ack_default <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      ack_restore = value;
   endtask

   task automatic set_idling(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
         default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
      endcase
   endtask

   // Closes whatever transfer is open with the events a real bus would raise.
   task automatic drain_open_transfer();
      while (bus_state != ST_READY) begin
         if (bus_state == ST_TX) begin
            send_event((tx_left != 0) ? (F_TXE | F_MT) : (F_BTF | F_MT),
                       8'($urandom), 8'($urandom));
         end else begin
            send_event(F_RXNE | F_MASTER, 8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic run_write(input logic [7:0] len);
      logic [7:0] extra;
      send_start(CMD_WRITE, 7'($urandom), len, 1'($urandom));
      send_event(F_SB | F_MT, 8'($urandom), 8'($urandom));
      send_event(F_ADDR | F_MT, 8'($urandom), 8'($urandom));
      repeat (len) begin
         extra = ($urandom_range(7) == 0) ? F_BTF : 8'h00;
         send_event(F_TXE | F_MT | extra, 8'($urandom), 8'($urandom));
      end
      extra = ($urandom_range(3) == 0) ? F_TXE : 8'h00;
      send_event(F_BTF | F_MT | extra, 8'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0) send_event(F_STOPF, 8'($urandom), 8'($urandom));
   endtask

   task automatic run_read(input logic [7:0] len);
      send_start(CMD_READ, 7'($urandom), len, 1'($urandom));
      send_event(F_SB | F_MASTER, 8'($urandom), 8'($urandom));
      send_event(F_ADDR | F_MASTER, 8'($urandom), 8'($urandom));
      repeat ((len == 0) ? 1 : len) begin
         send_event(F_RXNE | F_MASTER, 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(3) == 0) send_event(F_STOPF, 8'($urandom), 8'($urandom));
   endtask

   task automatic test_write_path();
      req_item_type it;
      set_idling(0);
      send_start(CMD_WRITE, 7'h7F, 8'd2, 1'b0);
      send_start(CMD_READ, 7'h00, 8'd0, 1'b0);
      send_event(F_SB | F_MT, 8'hFF, 8'h00);
      send_event(F_ADDR | F_MT, 8'h00, 8'hFF);
      send_event(F_TXE | F_MT, 8'hFF, 8'h00);
      send_event(F_TXE | F_MT, 8'h00, 8'hFF);
      send_event(F_TXE | F_MT, 8'h5A, 8'h00);
      send_event(F_TXE | F_TRA, 8'hA5, 8'h00);
      send_event(F_BTF | F_STOPF | F_MT, 8'h00, 8'h00);
      send_event(F_STOPF | F_SB, 8'h00, 8'h00);
      it = '1;
      send_item(it);
   endtask

   task automatic test_read_path();
      send_start(CMD_READ, 7'h55, 8'd1, 1'b1);
      send_start(CMD_WRITE, 7'h2A, 8'd1, 1'b0);
      send_event(F_SB | F_MASTER, 8'h00, 8'h00);
      send_event(F_ADDR | F_MASTER, 8'h00, 8'h00);
      send_event(F_RXNE, 8'h00, 8'h33);
      send_event(F_RXNE | F_MASTER, 8'h00, 8'hFF);
      wait_drained();
      write_ack_default(1'b0);
      send_start(CMD_READ, 7'h01, 8'd3, 1'b0);
      send_event(F_SB | F_ADDR | F_MASTER, 8'h00, 8'h00);
      repeat (3) send_event(F_RXNE | F_MASTER, 8'h00, 8'($urandom));
      send_start(CMD_READ, 7'h02, 8'd0, 1'b1);
      send_event(F_RXNE | F_MASTER, 8'h00, 8'hC3);
      send_start(CMD_WRITE, 7'h40, 8'd0, 1'b1);
      send_event(8'hFF, 8'h81, 8'h18);
      send_start(CMD_READ, 7'h3C, 8'd1, 1'b0);
      send_event(8'h3F, 8'h00, 8'h00);
      drain_open_transfer();
   endtask

   task automatic test_long_read();
      set_idling(3);
      drain_open_transfer();
      run_read(8'd64);
   endtask

   task automatic test_random_traffic();
      int target;
      int k;
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(phase);
         wait_drained();
         write_ack_default((phase == 1) ? 1'b0 : (phase == 3) ? 1'b1 : 1'($urandom));
         target = items_sent + RANDOM_ITEMS_PER_PHASE;
         while (items_sent < target) begin
            case ($urandom_range(9))
               0: send_item(random_item());
               1: begin
                  send_start(2'($urandom_range(1)), 7'($urandom), pick_length(),
                             1'($urandom));
                  k = $urandom_range(1, 3);
                  repeat (k) send_event(8'($urandom), 8'($urandom), 8'($urandom));
               end
               default: begin
                  drain_open_transfer();
                  if ($urandom_range(1)) run_write(pick_length());
                  else run_read(pick_length());
               end
            endcase
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.cmd            <= CMD_WRITE;
      req_ch.slave_addr     <= '0;
      req_ch.length         <= '0;
      req_ch.repeated_start <= 1'b0;
      req_ch.status_flags   <= '0;
      req_ch.tx_byte        <= '0;
      req_ch.rx_byte        <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.ack_default    <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_write_path();
      test_read_path();
      test_long_read();
      test_random_traffic();
      wait_drained();
      repeat (16) @(posedge clock);
      if (expected_actions.size() != 0) begin
         report_mismatch("expected results never arrived");
      end
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hdl/imes_pkg.sv
hdl/imes_req_if.sv
hdl/imes_rsp_if.sv
hdl/imes_csr_if.sv
hdl/imes_step.sv
hdl/imes_rsp_buf.sv
hdl/i2c_master_event_sequencer_unit.sv
dv/tb_top.sv
